// File: hw/rtl/ntmq_pkg.sv
// ntmq_pkg: shared types, codes and defaults for the nearest time measurement queue
// no dependencies; used by the cell, the cell chain and the top level

package ntmq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam logic [31:0] WINDOW_RST = 32'd60000;

    // item kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // query status codes
    localparam logic [1:0] STAT_FOUND   = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_TOO_OLD = 2'd2;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        bearing;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        spread;
    } t_entry;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic push;
        logic rotate;
    } t_chain_ctl;

endpackage

// File: hw/rtl/ntmq_if.sv
// ntmq_if: valid/ready channel interfaces for items, results and the window register
// depends on nothing; the top level uses all three

interface ntmq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        stamp_ms;
    logic [15:0]        bearing_cdeg;
    logic signed [31:0] pos_x_cm;
    logic signed [31:0] pos_y_cm;
    logic [15:0]        spread;

    modport source (output valid, kind, stamp_ms, bearing_cdeg, pos_x_cm, pos_y_cm, spread,
                    input ready);
    modport sink   (input valid, kind, stamp_ms, bearing_cdeg, pos_x_cm, pos_y_cm, spread,
                    output ready);
endinterface

interface ntmq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        match_ms;
    logic [15:0]        match_bearing_cdeg;
    logic signed [31:0] match_x_cm;
    logic signed [31:0] match_y_cm;
    logic [15:0]        match_spread;

    modport source (output valid, status, match_ms, match_bearing_cdeg, match_x_cm,
                    match_y_cm, match_spread, input ready);
    modport sink   (input valid, status, match_ms, match_bearing_cdeg, match_x_cm,
                    match_y_cm, match_spread, output ready);
endinterface

interface ntmq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/ntmq_cell.sv
// ntmq_cell: one queue slot, loads from its newer neighbour on push
// or from its older neighbour on rotate; depends on ntmq_pkg

module ntmq_cell (
    input  logic                  i_clk,
    input  ntmq_pkg::t_chain_ctl  i_ctl,
    input  ntmq_pkg::t_entry      i_from_newer,
    input  ntmq_pkg::t_entry      i_from_older,
    output ntmq_pkg::t_entry      o_entry
);
    import ntmq_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_newer;
        end else if (i_ctl.rotate) begin
            r_entry <= i_from_older;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: hw/rtl/ntmq_chain.sv
// ntmq_chain: row of DEPTH cells, newest at the head; push shifts towards the tail,
// rotate moves every entry one place towards the head, the head entry to the tail; depends on ntmq_pkg, ntmq_cell

module ntmq_chain #(
    parameter int DEPTH = ntmq_pkg::DEPTH_DEF
) (
    input  logic                  i_clk,
    input  ntmq_pkg::t_chain_ctl  i_ctl,
    input  ntmq_pkg::t_entry      i_new,
    output ntmq_pkg::t_entry      o_head
);
    import ntmq_pkg::*;

    t_entry w_cell [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ntmq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_from_newer ((g == 0) ? i_new : w_cell[(g + DEPTH - 1) % DEPTH]),
                .i_from_older (w_cell[(g + 1) % DEPTH]),
                .o_entry      (w_cell[g])
            );
        end
    endgenerate

    assign o_head = w_cell[0];

endmodule

// File: hw/rtl/nearest_time_measurement_queue.sv
// nearest_time_measurement_queue: a push is taken in idle and loads the head of the cell chain;
// a tick makes one full rotation of the cell chain past the head and then returns to idle;
// a query makes the same rotation, then waits in the done state until its result is registered,
// held off while an earlier result still waits to be taken; the next item can enter after that.
// One item at a time; a new item may enter while a result waits to be taken.
// Synchronous active-low reset empties the queue and sets the window to 60000 ms; slots keep data.

module nearest_time_measurement_queue #(
    parameter int DEPTH = ntmq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ntmq_in_if.sink             i_in,
    ntmq_out_if.source          o_out,
    ntmq_cfg_if.sink            i_cfg
);
    import ntmq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_kind;
    logic [31:0]   r_stamp;
    logic [AW-1:0] r_cnt;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_found, n_found;
    logic [1:0]    r_status, n_status;
    t_entry        r_res, n_res;
    t_entry        r_prev;
    logic [31:0]   r_window;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    t_entry        r_out;

    t_chain_ctl    w_ctl;
    t_entry        w_new;
    t_entry        w_head;
    logic          w_in_acc;
    logic          w_cur_valid;
    logic          w_last_valid;
    logic          w_load_out;
    logic [31:0]   w_d_old;
    logic [31:0]   w_d_new;
    logic [32:0]   w_limit;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_new = '{time_ms: i_in.stamp_ms, bearing: i_in.bearing_cdeg,
                     pos_x: i_in.pos_x_cm, pos_y: i_in.pos_y_cm, spread: i_in.spread};

    assign w_ctl = '{push: w_in_acc && (i_in.kind == KIND_PUSH),
                     rotate: (r_state == ST_SCAN)};

    ntmq_chain #(.DEPTH(DEPTH)) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_new  (w_new),
        .o_head (w_head)
    );

    // head holds the entry r_cnt places older than the newest
    assign w_cur_valid  = (FW'(r_cnt) < r_fill);
    assign w_last_valid = ((FW'(r_cnt) + FW'(1)) == r_fill);
    assign w_d_old      = r_stamp - w_head.time_ms;
    assign w_d_new      = r_prev.time_ms - r_stamp;
    assign w_limit      = {1'b0, w_head.time_ms} + {1'b0, r_window};
    assign w_load_out   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_found  = r_found;
        n_status = r_status;
        n_res    = r_res;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_found  = 1'b0;
                    n_status = STAT_EMPTY;
                    n_res    = '0;
                    case (i_in.kind)
                        KIND_PUSH: begin
                            if (r_fill != FW'(DEPTH)) begin
                                n_fill = r_fill + FW'(1);
                            end
                        end
                        KIND_QUERY, KIND_TICK: n_state = ST_SCAN;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_kind == KIND_QUERY) begin
                    if (w_cur_valid && !r_found
                        && ((w_head.time_ms <= r_stamp) || w_last_valid)) begin
                        n_found  = 1'b1;
                        n_status = STAT_FOUND;
                        // older candidate wins only when strictly nearer
                        if (r_cnt != '0 && !(w_d_old < w_d_new)) begin
                            n_res = r_prev;
                        end else begin
                            n_res = w_head;
                        end
                    end
                    if (w_last_valid && (r_stamp < w_head.time_ms)) begin
                        n_status = STAT_TOO_OLD;
                        n_res    = '0;
                    end
                end else begin
                    if (w_last_valid && ({1'b0, r_stamp} > w_limit)) begin
                        n_fill = r_fill - FW'(1);
                    end
                end
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = (r_kind == KIND_QUERY) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_found     <= 1'b0;
            r_window    <= WINDOW_RST;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_found <= n_found;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window <= i_cfg.data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + AW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_res    <= n_res;
        if (w_in_acc) begin
            r_kind  <= i_in.kind;
            r_stamp <= i_in.stamp_ms;
        end
        if (r_state == ST_SCAN) begin
            r_prev <= w_head;
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out        <= r_res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_out_status;
    assign o_out.match_ms           = r_out.time_ms;
    assign o_out.match_bearing_cdeg = r_out.bearing;
    assign o_out.match_x_cm         = r_out.pos_x;
    assign o_out.match_y_cm         = r_out.pos_y;
    assign o_out.match_spread       = r_out.spread;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_no_push_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_ctl.push)
        else $error("push transaction taken while chain rotates");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_cnt == AW'(DEPTH - 1)) |=> (r_state != ST_SCAN))
        else $error("scan overran one full rotation");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result transaction raised outside done state");
`endif

endmodule
